// ----- rtl/core/product_quantizer_encoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Product quantizer encoder assertion macros
// Shared assertion forms for the encoder core, clocked on clk and held off
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRODUCT_QUANTIZER_ENCODER_CORE_DEFINES_SVH
`define PRODUCT_QUANTIZER_ENCODER_CORE_DEFINES_SVH

// General check: the property must hold at every rising edge out of reset.
`define PQE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be seen at a rising edge out of reset.
`define PQE_NEVER(lbl, cond, msg) \
	`PQE_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/core/pqe_pkg.sv -----
// ----------------------------------------------------------------------------
// Product quantizer encoder package
// Default sizes, field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pqe_pkg;

	localparam int DEF_MAX_SUBVECTORS = 8;
	localparam int DEF_MAX_CENTROIDS  = 256;
	localparam int DEF_MAX_SUB_DIM    = 16;
	localparam int DEF_ELEMENT_BITS   = 16;

	localparam int VALUE_W    = 16;
	localparam int CODE_W     = 8;
	localparam int SUBSPACE_W = 3;
	localparam int CENTROID_W = 8;
	localparam int DIM_W      = 4;

	localparam int NSV_REG_W = 4;
	localparam int SD_REG_W  = 5;
	localparam int NC_REG_W  = 9;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_NUM_SUBVECTORS = 2'd0;
	localparam logic [1:0] REG_SUB_DIM        = 2'd1;
	localparam logic [1:0] REG_NUM_CENTROIDS  = 2'd2;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_ENCODE = 1'b1;

	// Position of one distance term within the search sweep.
	typedef struct packed {
		logic first_d;
		logic last_d;
		logic first_k;
		logic last_k;
	} pqe_tag_t;

endpackage

// ----- rtl/core/pqe_cell.sv -----
// ----------------------------------------------------------------------------
// Subvector cell
// Holds one element of the current subvector. An encode item writes the cell
// at its element position; during the sweep the cells form a ring that turns
// toward cell 0, with the tail cell taking the element leaving cell 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqe_cell import pqe_pkg::*; #(
	parameter int WORD_W = DEF_ELEMENT_BITS
) (
	input  logic              clk,
	input  logic              shift,
	input  logic              load,
	input  logic              tail,
	input  logic [WORD_W-1:0] nxt,
	input  logic [WORD_W-1:0] head,
	input  logic [WORD_W-1:0] din,
	output logic [WORD_W-1:0] val
);

	logic [WORD_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= din;
		end else if (shift) begin
			if (tail) begin
				val_q <= head;
			end else begin
				val_q <= nxt;
			end
		end
	end

	assign val = val_q;

endmodule

// ----- rtl/core/pqe_codebook.sv -----
// ----------------------------------------------------------------------------
// Codebook memory
// One write port for load items and one registered read port for the
// centroid sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqe_codebook import pqe_pkg::*; #(
	parameter int AW     = 15,
	parameter int WORD_W = DEF_ELEMENT_BITS
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [2**AW];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/pqe_search.sv -----
// ----------------------------------------------------------------------------
// Nearest centroid search
// Squares the difference of each element and codebook word, sums over the
// subvector and keeps the centroid with the smallest sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqe_search import pqe_pkg::*; #(
	parameter int WORD_W = DEF_ELEMENT_BITS,
	parameter int KW     = 8,
	parameter int SUM_W  = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              iss,
	input  pqe_tag_t          iss_tag,
	input  logic [KW-1:0]     iss_k,
	input  logic [WORD_W-1:0] iss_x,
	input  logic [WORD_W-1:0] cw,
	output logic              done,
	output logic [KW-1:0]     code
);

	localparam int DIFF_W = WORD_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;

	logic              v_s1, v_s2, done_q;
	pqe_tag_t          tag_s1, tag_s2;
	logic [KW-1:0]     k_s1, k_s2, bk_q, code_q;
	logic [WORD_W-1:0] x_s1;
	logic [SQ_W-1:0]   sq_s2;
	logic [SUM_W-1:0]  acc_q, best_q, total;

	logic signed [DIFF_W-1:0] diff;
	logic signed [SQ_W-1:0]   prod;
	logic                     better;

	always_comb begin
		diff   = $signed({x_s1[WORD_W-1], x_s1}) - $signed({cw[WORD_W-1], cw});
		prod   = diff * diff;
		total  = (tag_s2.first_d ? '0 : acc_q) + SUM_W'(sq_s2);
		better = tag_s2.first_k || (total < best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= iss;
			v_s2   <= v_s1;
			done_q <= v_s2 && tag_s2.last_d && tag_s2.last_k;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss_tag;
		k_s1   <= iss_k;
		x_s1   <= iss_x;
		tag_s2 <= tag_s1;
		k_s2   <= k_s1;
		sq_s2  <= $unsigned(prod);
		if (v_s2) begin
			acc_q <= total;
			if (tag_s2.last_d && better) begin
				best_q <= total;
				bk_q   <= k_s2;
			end
			code_q <= better ? k_s2 : bk_q;
		end
	end

	assign done = done_q;
	assign code = code_q;

endmodule

// ----- rtl/core/product_quantizer_encoder_core.sv -----
// Product quantizer encoder core.
// Input channel (in_valid / in_stall): each item either loads one codebook
// word (action = load) or brings the next element of the vector (action =
// encode). Output channel (out_valid / out_stall): one item per finished
// subvector, carrying the nearest centroid index, its subspace and a flag
// on the last subvector of the vector.
// Load items and encode items that do not end a subvector keep the core idle.
// The element that ends a subvector starts a sweep over the codebook, one
// word per cycle from the single read port, over every centroid and element
// in use; the result passes the read, square and compare stages before it
// reaches the output register. The input is stalled during the sweep and
// while a finished result is held by a stalled receiver.
// Reset clears the element and subspace positions and loads the default
// register values; codebook words are undefined until loaded.
// Registers sit on the APB port at 0x0, 0x4 and 0x8.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Product quantizer encoder core
// Top level: configuration registers, positions, sweep control, subvector
// cell ring, codebook and search.
// ----------------------------------------------------------------------------

module product_quantizer_encoder_core import pqe_pkg::*; #(
	parameter int MAX_SUBVECTORS = DEF_MAX_SUBVECTORS,
	parameter int MAX_CENTROIDS  = DEF_MAX_CENTROIDS,
	parameter int MAX_SUB_DIM    = DEF_MAX_SUB_DIM,
	parameter int ELEMENT_BITS   = DEF_ELEMENT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [SUBSPACE_W-1:0] entry_subspace,
	input  logic [CENTROID_W-1:0] entry_centroid,
	input  logic [DIM_W-1:0]      entry_dim,
	input  logic signed [VALUE_W-1:0] entry_value,
	input  logic signed [VALUE_W-1:0] element_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CODE_W-1:0]     code,
	output logic [SUBSPACE_W-1:0] code_subspace,
	output logic                  last_code,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	localparam int WORD_W = (ELEMENT_BITS < VALUE_W) ? ELEMENT_BITS : VALUE_W;
	localparam int SPW    = (MAX_SUBVECTORS > 1) ? $clog2(MAX_SUBVECTORS) : 1;
	localparam int KW     = $clog2(MAX_CENTROIDS);
	localparam int EPW    = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;
	localparam int AW     = SPW + KW + EPW;
	localparam int NSVW   = $clog2(MAX_SUBVECTORS + 1);
	localparam int SDW    = $clog2(MAX_SUB_DIM + 1);
	localparam int NCW    = $clog2(MAX_CENTROIDS + 1);
	localparam int SUM_W  = 2 * (WORD_W + 1) + $clog2(MAX_SUB_DIM) + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

	state_t               state_q;
	logic [NSV_REG_W-1:0] num_subvectors_q;
	logic [SD_REG_W-1:0]  sub_dim_q;
	logic [NC_REG_W-1:0]  num_centroids_q;
	logic [NSVW-1:0]      nsv_eff;
	logic [SDW-1:0]       sd_eff;
	logic [NCW-1:0]       nc_eff;

	logic [EPW-1:0]        ep_q, ep_cur, d_q;
	logic [SPW-1:0]        sp_q, sp_cur, sp_run_q;
	logic [KW-1:0]         k_q;
	logic                  last_run_q;
	logic                  out_valid_q, last_code_q;
	logic [CODE_W-1:0]     code_q;
	logic [SUBSPACE_W-1:0] code_subspace_q;

	logic        cfg_wr, acc, acc_load, acc_enc, sub_end, sv_last;
	logic        load_ok, issue, last_d, last_k;
	pqe_tag_t    iss_tag;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] cw, elem_word, load_word;
	logic [WORD_W-1:0] cell_val [MAX_SUB_DIM];
	logic              srch_done;
	logic [KW-1:0]     srch_code;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_subvectors_q <= NSV_REG_W'(8);
			sub_dim_q        <= SD_REG_W'(16);
			num_centroids_q  <= NC_REG_W'(256);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NUM_SUBVECTORS: num_subvectors_q <= pwdata[NSV_REG_W-1:0];
				REG_SUB_DIM:        sub_dim_q        <= pwdata[SD_REG_W-1:0];
				REG_NUM_CENTROIDS:  num_centroids_q  <= pwdata[NC_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_SUBVECTORS: prdata = PDATA_W'(num_subvectors_q);
			REG_SUB_DIM:        prdata = PDATA_W'(sub_dim_q);
			REG_NUM_CENTROIDS:  prdata = PDATA_W'(num_centroids_q);
			default:            prdata = '0;
		endcase
	end

	// Register values in use: zero acts as one, too large acts as the maximum.
	always_comb begin
		if (num_subvectors_q == '0) nsv_eff = NSVW'(1);
		else if (32'(num_subvectors_q) > 32'(MAX_SUBVECTORS)) nsv_eff = NSVW'(MAX_SUBVECTORS);
		else nsv_eff = NSVW'(num_subvectors_q);
		if (sub_dim_q == '0) sd_eff = SDW'(1);
		else if (32'(sub_dim_q) > 32'(MAX_SUB_DIM)) sd_eff = SDW'(MAX_SUB_DIM);
		else sd_eff = SDW'(sub_dim_q);
		if (num_centroids_q == '0) nc_eff = NCW'(1);
		else if (32'(num_centroids_q) > 32'(MAX_CENTROIDS)) nc_eff = NCW'(MAX_CENTROIDS);
		else nc_eff = NCW'(num_centroids_q);
	end

	// Input handshake and positions.
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign acc_load = acc && (action == ACT_LOAD);
	assign acc_enc  = acc && (action == ACT_ENCODE);

	always_comb begin
		ep_cur  = (32'(ep_q) >= 32'(sd_eff)) ? '0 : ep_q;
		sp_cur  = (32'(sp_q) >= 32'(nsv_eff)) ? '0 : sp_q;
		sub_end = (32'(ep_cur) + 32'd1 >= 32'(sd_eff));
		sv_last = (32'(sp_cur) + 32'd1 >= 32'(nsv_eff));
	end

	assign load_ok = (32'(entry_subspace) < 32'(MAX_SUBVECTORS))
		&& (32'(entry_centroid) < 32'(MAX_CENTROIDS))
		&& (32'(entry_dim) < 32'(MAX_SUB_DIM));
	assign waddr     = {SPW'(entry_subspace), KW'(entry_centroid), EPW'(entry_dim)};
	assign load_word = entry_value[WORD_W-1:0];
	assign elem_word = element_value[WORD_W-1:0];

	// Sweep over centroids and dimensions.
	assign issue  = (state_q == ST_RUN);
	assign last_d = (32'(d_q) + 32'd1 == 32'(sd_eff));
	assign last_k = (32'(k_q) + 32'd1 == 32'(nc_eff));
	assign raddr  = {sp_run_q, k_q, d_q};

	always_comb begin
		iss_tag.first_d = (d_q == '0);
		iss_tag.last_d  = last_d;
		iss_tag.first_k = (k_q == '0);
		iss_tag.last_k  = last_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ep_q        <= '0;
			sp_q        <= '0;
			d_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_enc) begin
						if (sub_end) begin
							ep_q       <= '0;
							sp_q       <= sv_last ? '0 : sp_cur + SPW'(1);
							sp_run_q   <= sp_cur;
							last_run_q <= sv_last;
							d_q        <= '0;
							k_q        <= '0;
							state_q    <= ST_RUN;
						end else begin
							ep_q <= ep_cur + EPW'(1);
						end
					end
				end
				ST_RUN: begin
					if (last_d) begin
						d_q <= '0;
						if (last_k) begin
							k_q     <= '0;
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + KW'(1);
						end
					end else begin
						d_q <= d_q + EPW'(1);
					end
				end
				ST_WAIT: begin
					if (srch_done) begin
						out_valid_q     <= 1'b1;
						code_q          <= CODE_W'(srch_code);
						code_subspace_q <= SUBSPACE_W'(sp_run_q);
						last_code_q     <= last_run_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Ring of subvector cells; cell 0 presents the element of the current term.
	// An encode item writes the cell at its element position.
	for (genvar i = 0; i < MAX_SUB_DIM; i++) begin : g_cell
		pqe_cell #(.WORD_W(WORD_W)) u_cell (
			.clk   (clk),
			.shift (issue),
			.load  (acc_enc && (32'(i) == 32'(ep_cur))),
			.tail  (32'(i) + 32'd1 == 32'(sd_eff)),
			.nxt   (cell_val[(i + 1) % MAX_SUB_DIM]),
			.head  (cell_val[0]),
			.din   (elem_word),
			.val   (cell_val[i])
		);
	end

	pqe_codebook #(.AW(AW), .WORD_W(WORD_W)) u_codebook (
		.clk   (clk),
		.we    (acc_load && load_ok),
		.waddr (waddr),
		.wdata (load_word),
		.re    (issue),
		.raddr (raddr),
		.rdata (cw)
	);

	pqe_search #(.WORD_W(WORD_W), .KW(KW), .SUM_W(SUM_W)) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.iss     (issue),
		.iss_tag (iss_tag),
		.iss_k   (k_q),
		.iss_x   (cell_val[0]),
		.cw      (cw),
		.done    (srch_done),
		.code    (srch_code)
	);

	assign out_valid     = out_valid_q;
	assign code          = code_q;
	assign code_subspace = code_subspace_q;
	assign last_code     = last_code_q;

`include "product_quantizer_encoder_core_defines.svh"

	`PQE_ASSERT(a_done_in_wait, srch_done |-> (state_q == ST_WAIT), "search result outside wait")
	`PQE_NEVER(a_no_overwrite, srch_done && out_valid_q, "result would overwrite held item")
	`PQE_ASSERT(a_sweep_end, (issue && last_d && last_k) |=> (d_q == '0 && k_q == '0), "sweep counters not cleared")

endmodule
